[rtl/sspc_pkg.sv]
// shared types and constants for the soft-sphere contact force core
`timescale 1ns / 1ps
package sspc_pkg;

	// register indexes
	localparam logic [1:0] REG_STIFFNESS = 2'd0;
	localparam logic [1:0] REG_DAMPING   = 2'd1;
	localparam logic [1:0] REG_RANGE     = 2'd2;

	localparam logic [63:0] MAG_MAX = 64'h0000_7FFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] p_center_x;
		logic signed [31:0] p_center_y;
		logic signed [31:0] q_center_x;
		logic signed [31:0] q_center_y;
		logic [30:0]        p_radius;
		logic [30:0]        q_radius;
		logic signed [31:0] p_vel_x;
		logic signed [31:0] p_vel_y;
		logic signed [31:0] q_vel_x;
		logic signed [31:0] q_vel_y;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic               in_contact;
		logic               coincident;
		logic               saturated;
	} force_t;

	typedef struct packed {
		logic [31:0] stiffness;
		logic [31:0] damping;
		logic [30:0] range;
	} coef_t;

endpackage

[rtl/sspc_stream_if.sv]
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
interface sspc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sspc_regs.sv]
// apb configuration registers
`timescale 1ns / 1ps
module sspc_regs
	import sspc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output coef_t       coef
);
	logic [31:0] stiff_q;
	logic [31:0] damp_q;
	logic [30:0] range_q;
	logic [1:0]  idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= '0;
			damp_q  <= '0;
			range_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (idx == REG_STIFFNESS) stiff_q <= pwdata;
			if (idx == REG_DAMPING)   damp_q  <= pwdata;
			if (idx == REG_RANGE)     range_q <= pwdata[30:0];
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		if (idx == REG_STIFFNESS) prdata = stiff_q;
		else if (idx == REG_DAMPING) prdata = damp_q;
		else if (idx == REG_RANGE) prdata = {1'b0, range_q};
	end

	assign coef = '{stiffness: stiff_q, damping: damp_q, range: range_q};
endmodule

[rtl/sspc_sqrt_pipe.sv]
// pipelined restoring square root, one result bit per stage, with sideband
`timescale 1ns / 1ps
module sspc_sqrt_pipe #(
	parameter int RW = 66,
	parameter int QW = 33,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rad,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] root,
	output logic [SW-1:0] side_out
);
	localparam int AW = 2 * QW + 2;

	logic [AW-1:0] rem_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [SW-1:0] sd_s  [QW+1];

	assign rem_s[0] = AW'(rad);
	assign q_s[0]   = '0;
	assign sd_s[0]  = side_in;

	// each stage decides one bit, msb first
	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int B = QW - 1 - i;
		logic [AW-1:0] trial;
		logic [AW-1:0] sub;
		assign trial = ({{(AW-QW){1'b0}}, q_s[i]} << (B + 1)) | (AW'(1) << (2 * B));
		assign sub   = rem_s[i] - trial;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[i] >= trial) begin
					rem_s[i+1] <= sub;
					q_s[i+1]   <= q_s[i] | (QW'(1) << B);
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1]   <= q_s[i];
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign root     = q_s[QW];
	assign side_out = sd_s[QW];
endmodule

[rtl/sspc_div_pipe.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module sspc_div_pipe #(
	parameter int NW = 48,
	parameter int DW = 33,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [DW:0]   r_s [NW+1];
	logic [NW-1:0] n_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic [SW-1:0] sd_s [NW+1];

	assign r_s[0]  = '0;
	assign n_s[0]  = num;
	assign d_s[0]  = den;
	assign sd_s[0] = side_in;

	// shift in one numerator bit, subtract when it fits
	for (genvar i = 0; i < NW; i++) begin : g_bit
		logic [DW+1:0] sh;
		assign sh = {r_s[i], n_s[i][NW-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (sh >= {2'b00, d_s[i]}) r_s[i+1] <= (DW+1)'(sh - {2'b00, d_s[i]});
				else                        r_s[i+1] <= sh[DW:0];
				n_s[i+1]  <= {n_s[i][NW-2:0], (sh >= {2'b00, d_s[i]})};
				d_s[i+1]  <= d_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign quo      = n_s[NW];
	assign side_out = sd_s[NW];
endmodule

[rtl/soft_sphere_pair_contact_force_core.sv]
// soft-sphere pair contact force core: top level pipeline
// throughput: one pair per cycle while the skid register is empty; every stage is a register row,
// so the root and divide pipelines set the latency and only a stalled output limits the rate
// a beat the receiver does not take moves to a one-beat skid register; the pipeline halts while it is full
// reset clears valid bits and configuration registers; payload registers are not reset
`timescale 1ns / 1ps
module soft_sphere_pair_contact_force_core
	import sspc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sspc_stream_if.sink   pair_in,
	sspc_stream_if.source force_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int LAT = 3 + 33 + 1 + 32 + 3 + 48 + 3;

	coef_t coef;
	sspc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coef
	);

	// global advance: move unless the skid register holds an untaken beat
	logic adv;
	logic [LAT-1:0] vld_q;
	logic skid_vld_q;
	force_t skid_q;
	assign adv           = !skid_vld_q;
	assign pair_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[LAT-2:0], pair_in.valid};
	end

	// stage 1: differences and contact reach
	pair_t pin;
	assign pin = pair_in.data;
	logic signed [32:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [32:0] reach_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= 33'(pin.p_center_x) - 33'(pin.q_center_x);
			dy_s1    <= 33'(pin.p_center_y) - 33'(pin.q_center_y);
			dvx_s1   <= 33'(pin.p_vel_x) - 33'(pin.q_vel_x);
			dvy_s1   <= 33'(pin.p_vel_y) - 33'(pin.q_vel_y);
			reach_s1 <= 33'(pin.p_radius) + 33'(pin.q_radius) + 33'(coef.range);
		end
	end

	// stage 2: magnitudes squared
	logic signed [32:0] dx_s2, dy_s2, dvx_s2, dvy_s2;
	logic [32:0] reach_s2;
	logic [63:0] sqx_s2, sqy_s2;
	logic [31:0] ax1, ay1;
	assign ax1 = dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
	assign ay1 = dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s2 <= dx_s1; dy_s2 <= dy_s1; dvx_s2 <= dvx_s1; dvy_s2 <= dvy_s1;
			reach_s2 <= reach_s1;
			sqx_s2 <= (dx_s1 == -33'sd4294967296) ? 64'd0 : ax1 * ax1;
			sqy_s2 <= (dy_s1 == -33'sd4294967296) ? 64'd0 : ay1 * ay1;
		end
	end
	// |d| would reach 2^32 only at -2^32, which a difference of 32-bit values cannot give; fold it into the sum
	logic [1:0] big2;
	assign big2 = {dy_s2 == -33'sd4294967296, dx_s2 == -33'sd4294967296};

	// stage 3: radicand
	localparam int SB = 33 * 4 + 33;
	logic [65:0] rad_s3;
	logic [SB-1:0] sb_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3 <= 66'(sqx_s2) + 66'(sqy_s2) + (66'(big2[0]) << 64) + (66'(big2[1]) << 64);
			sb_s3  <= {dx_s2, dy_s2, dvx_s2, dvy_s2, reach_s2};
		end
	end

	logic [32:0] d_root;
	logic [SB-1:0] sb_r1;
	sspc_sqrt_pipe #(.RW(66), .QW(33), .SW(SB)) u_root_d (
		.clk, .en(adv), .rad(rad_s3), .side_in(sb_s3), .root(d_root), .side_out(sb_r1)
	);

	// stage 4: contact test, coincidence test and overlap
	logic signed [32:0] dx_s4, dy_s4, dvx_s4, dvy_s4;
	logic [32:0] ov_s4, d_s4;
	logic cont_s4, coin_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			{dx_s4, dy_s4, dvx_s4, dvy_s4} <= sb_r1[SB-1:33];
			d_s4    <= d_root;
			cont_s4 <= d_root <= sb_r1[32:0];
			ov_s4   <= sb_r1[32:0] - d_root;
			coin_s4 <= (sb_r1[SB-1:SB-33] == '0) && (sb_r1[SB-34:SB-66] == '0);
		end
	end

	// overlap root over 49-bit radicand, sideband carries the rest
	localparam int SB2 = 33 * 6 + 2;
	logic [31:0] oroot;
	logic [SB2-1:0] sb_r2;
	sspc_sqrt_pipe #(.RW(50), .QW(25), .SW(SB2)) u_root_o_lo (
		.clk, .en(adv), .rad({1'b0, ov_s4, 16'b0}), .side_in(
			{dx_s4, dy_s4, dvx_s4, dvy_s4, ov_s4, d_s4, cont_s4, coin_s4}),
		.root(oroot[24:0]), .side_out(sb_r2)
	);
	assign oroot[31:25] = '0;
	// padding stages behind the overlap root, carrying its result and sideband
	logic [SB2+31:0] pad_q [7];
	always_ff @(posedge clk) begin
		if (adv) begin
			pad_q[0] <= {oroot, sb_r2};
			for (int i = 1; i < 7; i++) pad_q[i] <= pad_q[i-1];
		end
	end

	// stage 5: overlap^1.5
	logic signed [32:0] dx_s5, dy_s5, dvx_s5, dvy_s5;
	logic [32:0] d_s5;
	logic cont_s5, coin_s5;
	logic [57:0] p_s5;
	logic [32:0] ov_pad;
	logic [31:0] s_pad;
	assign s_pad  = pad_q[6][SB2+31:SB2];
	assign ov_pad = pad_q[6][67:35];
	always_ff @(posedge clk) begin
		if (adv) begin
			{dx_s5, dy_s5, dvx_s5, dvy_s5} <= pad_q[6][SB2-1:68];
			d_s5    <= pad_q[6][34:2];
			cont_s5 <= pad_q[6][1];
			coin_s5 <= pad_q[6][0];
			p_s5    <= 58'((66'(ov_pad) * 66'(s_pad)) >> 16);
		end
	end

	// stage 6: k*p split in two 32x29 products
	logic [60:0] kl_s6, kh_s6;
	logic signed [32:0] dx_s6, dy_s6, dvx_s6, dvy_s6;
	logic [32:0] d_s6;
	logic cont_s6, coin_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			kl_s6 <= coef.stiffness * p_s5[28:0];
			kh_s6 <= coef.stiffness * p_s5[57:29];
			{dx_s6, dy_s6, dvx_s6, dvy_s6, d_s6, cont_s6, coin_s6}
				<= {dx_s5, dy_s5, dvx_s5, dvy_s5, d_s5, cont_s5, coin_s5};
		end
	end

	// stage 7: spring magnitude with clip
	logic [90:0] kp;
	assign kp = 91'(kl_s6) + (91'(kh_s6) << 29);
	logic [47:0] mag_s7;
	logic mclip_s7;
	logic signed [32:0] dx_s7, dy_s7, dvx_s7, dvy_s7;
	logic [32:0] d_s7;
	logic cont_s7, coin_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			mclip_s7 <= kp[90:63] != '0;
			mag_s7   <= (kp[90:63] != '0) ? MAG_MAX[47:0] : kp[63:16];
			{dx_s7, dy_s7, dvx_s7, dvy_s7, d_s7, cont_s7, coin_s7}
				<= {dx_s6, dy_s6, dvx_s6, dvy_s6, d_s6, cont_s6, coin_s6};
		end
	end

	// stage 8: normal components by pipelined division, x side carries the flags
	localparam int SBX = 48 + 1 + 33 * 2 + 2;
	localparam int SBY = 33 * 2;
	logic [47:0] nxq, nyq;
	logic [SBX-1:0] sb_dvx;
	logic [SBY-1:0] sb_dvy;
	logic [32:0] adx7, ady7, dsafe;
	assign adx7  = dx_s7[32] ? 33'(-dx_s7) : dx_s7;
	assign ady7  = dy_s7[32] ? 33'(-dy_s7) : dy_s7;
	assign dsafe = (d_s7 == '0) ? 33'd1 : d_s7;
	sspc_div_pipe #(.NW(48), .DW(33), .SW(SBX)) u_div_x (
		.clk, .en(adv), .num({adx7[31:0], 16'b0}), .den(dsafe), .side_in(
			{mag_s7, mclip_s7, dx_s7, dvx_s7, cont_s7, coin_s7}),
		.quo(nxq), .side_out(sb_dvx)
	);
	sspc_div_pipe #(.NW(48), .DW(33), .SW(SBY)) u_div_y (
		.clk, .en(adv), .num({ady7[31:0], 16'b0}), .den(dsafe), .side_in(
			{dy_s7, dvy_s7}),
		.quo(nyq), .side_out(sb_dvy)
	);

	// stage 9: products of magnitude and damping
	logic [47:0] mag9;
	logic clip9, cont9, coin9;
	logic signed [32:0] dx9, dy9, dvx9, dvy9;
	assign {mag9, clip9, dx9, dvx9, cont9, coin9} = sb_dvx;
	assign {dy9, dvy9} = sb_dvy;
	logic [32:0] advx, advy;
	assign advx = dvx9[32] ? 33'(-dvx9) : dvx9;
	assign advy = dvy9[32] ? 33'(-dvy9) : dvy9;
	logic [64:0] smx_s9, smy_s9, dmx_s9, dmy_s9;
	logic sx_s9, sy_s9, svx_s9, svy_s9, clip_s9, cont_s9, coin_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			smx_s9 <= 65'(mag9) * 65'(nxq[16:0]);
			smy_s9 <= 65'(mag9) * 65'(nyq[16:0]);
			dmx_s9 <= 65'(coef.damping) * 65'(advx);
			dmy_s9 <= 65'(coef.damping) * 65'(advy);
			sx_s9 <= dx9[32]; sy_s9 <= dy9[32];
			svx_s9 <= dvx9[32]; svy_s9 <= dvy9[32];
			clip_s9 <= clip9; cont_s9 <= cont9; coin_s9 <= coin9;
		end
	end

	// stage 10: signed sums
	logic signed [50:0] fx_s10, fy_s10;
	logic clip_s10, cont_s10, coin_s10;
	logic signed [50:0] spx, spy, dpx, dpy;
	assign spx = 51'(smx_s9 >> 16);
	assign spy = 51'(smy_s9 >> 16);
	assign dpx = 51'(dmx_s9 >> 16);
	assign dpy = 51'(dmy_s9 >> 16);
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s10 <= (sx_s9 ? -spx : spx) + (svx_s9 ? -dpx : dpx);
			fy_s10 <= (sy_s9 ? -spy : spy) + (svy_s9 ? -dpy : dpy);
			clip_s10 <= clip_s9; cont_s10 <= cont_s9; coin_s10 <= coin_s9;
		end
	end

	// stage 11: saturate and build the result beat
	function automatic logic [32:0] sat32(input logic signed [50:0] v);
		if (v > 51'sd2147483647)       return {1'b1, 32'h7FFF_FFFF};
		else if (v < -51'sd2147483648) return {1'b1, 32'h8000_0000};
		else                           return {1'b0, v[31:0]};
	endfunction
	logic [32:0] cx, cy;
	assign cx = sat32(fx_s10);
	assign cy = sat32(fy_s10);
	force_t res_s11;
	always_ff @(posedge clk) begin
		if (adv) begin
			if (!cont_s10 || coin_s10) begin
				res_s11 <= '{force_x: '0, force_y: '0, in_contact: cont_s10,
					coincident: cont_s10 && coin_s10, saturated: 1'b0};
			end else begin
				res_s11 <= '{force_x: cx[31:0], force_y: cy[31:0], in_contact: 1'b1,
					coincident: 1'b0, saturated: clip_s10 || cx[32] || cy[32]};
			end
		end
	end

	// skid register: catches the last stage beat when the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			if (vld_q[LAT-1] && !force_out.ready) skid_vld_q <= 1'b1;
		end else if (force_out.ready) begin
			skid_vld_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[LAT-1] && !force_out.ready) skid_q <= res_s11;
	end

	assign force_out.valid = skid_vld_q || vld_q[LAT-1];
	assign force_out.data  = skid_vld_q ? skid_q : res_s11;

	// output beat has consistent flags and forces, and stays valid while stalled
	a_coin_needs_contact: assert property (@(posedge clk) disable iff (!arst_n)
		force_out.valid |-> (!force_out.data.coincident || force_out.data.in_contact))
		else $error("coincident without contact");
	a_nocontact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(force_out.valid && !force_out.data.in_contact) |->
		(force_out.data.force_x == 0 && force_out.data.force_y == 0))
		else $error("force outside contact");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(force_out.valid && !force_out.ready) |=> force_out.valid)
		else $error("result dropped while stalled");
endmodule
